@@ hdl/ialu_pkg.sv @@
// ialu_pkg: opcodes, widths and transaction types of the 64-bit integer alu
// no dependencies

package ialu_pkg;

	localparam int DATA_BITS = 64;
	localparam int OPC_BITS  = 6;
	localparam int FLAG_BITS = 4;
	localparam int TAG_BITS  = 6;

	localparam logic [OPC_BITS-1:0] OP_ADD   = 6'h00;
	localparam logic [OPC_BITS-1:0] OP_SUB   = 6'h01;
	localparam logic [OPC_BITS-1:0] OP_ADC   = 6'h02;
	localparam logic [OPC_BITS-1:0] OP_SBC   = 6'h03;
	localparam logic [OPC_BITS-1:0] OP_AND   = 6'h06;
	localparam logic [OPC_BITS-1:0] OP_ORR   = 6'h07;
	localparam logic [OPC_BITS-1:0] OP_EOR   = 6'h08;
	localparam logic [OPC_BITS-1:0] OP_BIC   = 6'h09;
	localparam logic [OPC_BITS-1:0] OP_LSL   = 6'h0A;
	localparam logic [OPC_BITS-1:0] OP_LSR   = 6'h0B;
	localparam logic [OPC_BITS-1:0] OP_ASR   = 6'h0C;
	localparam logic [OPC_BITS-1:0] OP_ROR   = 6'h0D;
	localparam logic [OPC_BITS-1:0] OP_ADDS  = 6'h0E;
	localparam logic [OPC_BITS-1:0] OP_SUBS  = 6'h0F;
	localparam logic [OPC_BITS-1:0] OP_ADCS  = 6'h10;
	localparam logic [OPC_BITS-1:0] OP_SBCS  = 6'h11;
	localparam logic [OPC_BITS-1:0] OP_ANDS  = 6'h14;
	localparam logic [OPC_BITS-1:0] OP_ORRS  = 6'h15;
	localparam logic [OPC_BITS-1:0] OP_EORS  = 6'h16;
	localparam logic [OPC_BITS-1:0] OP_BICS  = 6'h17;
	localparam logic [OPC_BITS-1:0] OP_LSLS  = 6'h18;
	localparam logic [OPC_BITS-1:0] OP_LSRS  = 6'h19;
	localparam logic [OPC_BITS-1:0] OP_ASRS  = 6'h1A;
	localparam logic [OPC_BITS-1:0] OP_RORS  = 6'h1B;
	localparam logic [OPC_BITS-1:0] OP_INC   = 6'h1C;
	localparam logic [OPC_BITS-1:0] OP_DEC   = 6'h1D;
	localparam logic [OPC_BITS-1:0] OP_MOV   = 6'h31;
	localparam logic [OPC_BITS-1:0] OP_MVN   = 6'h32;
	localparam logic [OPC_BITS-1:0] OP_FMOV  = 6'h33;
	localparam logic [OPC_BITS-1:0] OP_MVNS  = 6'h34;
	localparam logic [OPC_BITS-1:0] OP_MOVR  = 6'h35;
	localparam logic [OPC_BITS-1:0] OP_FNEG  = 6'h36;
	localparam logic [OPC_BITS-1:0] OP_CMP   = 6'h37;
	localparam logic [OPC_BITS-1:0] OP_CMN   = 6'h38;
	localparam logic [OPC_BITS-1:0] OP_TST   = 6'h39;
	localparam logic [OPC_BITS-1:0] OP_TEQ   = 6'h3A;
	localparam logic [OPC_BITS-1:0] OP_CMP_W = 6'h3B;
	localparam logic [OPC_BITS-1:0] OP_CMN_W = 6'h3C;
	localparam logic [OPC_BITS-1:0] OP_TST_W = 6'h3D;
	localparam logic [OPC_BITS-1:0] OP_TEQ_W = 6'h3E;

	localparam logic [DATA_BITS-1:0] SIGN_BIT = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic [OPC_BITS-1:0]  opcode;
		logic [DATA_BITS-1:0] operand_a;
		logic [DATA_BITS-1:0] operand_b;
		logic [FLAG_BITS-1:0] flags_in;
		logic                 needs_flags;
		logic                 modify_flags;
		logic [TAG_BITS-1:0]  dest_tag;
	} req_t;

	typedef struct packed {
		logic [DATA_BITS-1:0] result_value;
		logic [FLAG_BITS-1:0] flags_out;
		logic                 flags_valid;
		logic [TAG_BITS-1:0]  result_tag;
	} rsp_t;

endpackage

@@ hdl/ialu_exec.sv @@
// ialu_exec: combinational datapath, one shared 65-bit adder, barrel shifter, logic ops
// depends on ialu_pkg

module ialu_exec (
	input  ialu_pkg::req_t req,
	output ialu_pkg::rsp_t rsp
);
	import ialu_pkg::*;

	logic [DATA_BITS-1:0]   a;
	logic [DATA_BITS-1:0]   b;
	logic                   cin;
	logic [DATA_BITS-1:0]   add_y;
	logic                   add_ci;
	logic [DATA_BITS:0]     sum;
	logic                   add_v;
	logic [5:0]             sh;
	logic [6:0]             lsl_idx;
	logic                   lsl_c;
	logic                   rsh_c;
	logic [2*DATA_BITS-1:0] rot2;
	logic [DATA_BITS-1:0]   raw;
	logic                   c;
	logic                   v;
	logic                   discard;

	assign a   = req.operand_a;
	assign b   = req.operand_b;
	assign cin = req.needs_flags & req.flags_in[1];

	// adder operand select
	always_comb begin
		add_y  = b;
		add_ci = 1'b0;
		unique case (req.opcode)
			OP_SUB, OP_SUBS, OP_CMP, OP_CMP_W: begin
				add_y  = ~b;
				add_ci = 1'b1;
			end
			OP_ADC, OP_ADCS: begin
				add_ci = cin;
			end
			OP_SBC, OP_SBCS: begin
				add_y  = ~b;
				add_ci = cin;
			end
			OP_INC: begin
				add_y  = '0;
				add_ci = 1'b1;
			end
			OP_DEC: begin
				add_y  = ~64'd1;
				add_ci = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign sum   = {1'b0, a} + {1'b0, add_y} + {{DATA_BITS{1'b0}}, add_ci};
	assign add_v = ~(a[63] ^ add_y[63]) & (a[63] ^ sum[63]);

	// shifter
	assign sh      = b[5:0];
	assign lsl_idx = 7'd64 - {1'b0, sh};
	assign lsl_c   = (sh != 6'd0) & a[lsl_idx[5:0]];
	assign rsh_c   = (sh != 6'd0) & a[sh - 6'd1];
	assign rot2    = {a, a} >> sh;

	always_comb begin
		raw     = '0;
		c       = 1'b0;
		v       = 1'b0;
		discard = 1'b0;
		unique case (req.opcode)
			OP_ADD, OP_ADDS, OP_SUB, OP_SUBS, OP_ADC, OP_ADCS,
			OP_SBC, OP_SBCS, OP_INC, OP_DEC: begin
				raw = sum[DATA_BITS-1:0];
				c   = sum[DATA_BITS];
				v   = add_v;
			end
			OP_CMP, OP_CMP_W, OP_CMN, OP_CMN_W: begin
				raw     = sum[DATA_BITS-1:0];
				c       = sum[DATA_BITS];
				v       = add_v;
				discard = 1'b1;
			end
			OP_AND, OP_ANDS: raw = a & b;
			OP_ORR, OP_ORRS: raw = a | b;
			OP_EOR, OP_EORS: raw = a ^ b;
			OP_BIC, OP_BICS: raw = a & ~b;
			OP_LSL, OP_LSLS: begin
				raw = a << sh;
				c   = lsl_c;
			end
			OP_LSR, OP_LSRS: begin
				raw = a >> sh;
				c   = rsh_c;
			end
			OP_ASR, OP_ASRS: begin
				raw = $unsigned($signed(a) >>> sh);
				c   = rsh_c;
			end
			OP_ROR, OP_RORS: begin
				raw = rot2[DATA_BITS-1:0];
				c   = rsh_c;
			end
			OP_MOV, OP_FMOV, OP_MOVR: raw = b;
			OP_MVN, OP_MVNS:          raw = ~b;
			OP_FNEG:                  raw = b ^ SIGN_BIT;
			OP_TST, OP_TST_W: begin
				raw     = a & b;
				discard = 1'b1;
			end
			OP_TEQ, OP_TEQ_W: begin
				raw     = a ^ b;
				discard = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		rsp.result_value = discard ? '0 : raw;
		rsp.flags_out    = req.modify_flags ? {raw[63], (raw == '0), c, v} : '0;
		rsp.flags_valid  = req.modify_flags;
		rsp.result_tag   = req.dest_tag;
	end

endmodule

@@ hdl/integer_alu_with_nzcv_flags.sv @@
// pipeline: an input transaction passes the input register, then the result register, before result valid
// throughput: one transaction per cycle; the input stalls in every cycle in which the result
// register holds a transaction that is not taken
// reset: arst_n clears both stage valid bits; payload registers are not reset
// depends on ialu_pkg, ialu_exec

module integer_alu_with_nzcv_flags (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  ialu_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output ialu_pkg::rsp_t rsp
);
	import ialu_pkg::*;

	logic vld_s1;
	logic vld_s2;
	logic adv;
	req_t req_s1;
	rsp_t rsp_s2;
	rsp_t exec_rsp;

	assign adv       = !vld_s2 || rsp_ready;
	assign req_ready = adv;
	assign rsp_valid = vld_s2;
	assign rsp       = rsp_s2;

	ialu_exec u_exec (
		.req (req_s1),
		.rsp (exec_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && req_valid) begin
			req_s1 <= req;
		end
		if (adv && vld_s1) begin
			rsp_s2 <= exec_rsp;
		end
	end

endmodule

@@ hdl/ialu_chk.sv @@
// ialu_chk: port-level checks on the alu's transaction timing and flag outputs
// depends on ialu_pkg; bound to integer_alu_with_nzcv_flags

module ialu_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input ialu_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input ialu_pkg::rsp_t rsp
);
	import ialu_pkg::*;

	// result held while stalled
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// empty output stage never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("input stalled with empty output");

	// accepted transaction reaches the output when not back-pressured
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) ##1 rsp_ready |=> rsp_valid)
		else $error("transaction lost in pipeline");

	// flags zero unless requested
	a_flags_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.flags_valid |-> rsp.flags_out == '0)
		else $error("flags driven without request");

endmodule

bind integer_alu_with_nzcv_flags ialu_chk u_chk (.*);
